### rtl/xxh64_pkg.sv
`default_nettype none
package xxh64_pkg;

  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] STRIPE_BYTES = 64'd32;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  n;
    logic        last;
    logic        first;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RND_MUL,
    ST_RND_ACC,
    ST_RND_FIN,
    ST_CONV,
    ST_MRG_A,
    ST_MRG_B,
    ST_MRG_C,
    ST_MRG_D,
    ST_LEN,
    ST_W_A,
    ST_W_B,
    ST_W_C,
    ST_W_D,
    ST_W_E,
    ST_H4_A,
    ST_H4_B,
    ST_H4_C,
    ST_B_A,
    ST_B_B,
    ST_B_C,
    ST_AV_A,
    ST_AV_B,
    ST_AV_C,
    ST_OUT
  } state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] d;
    begin
      d = {x, x} << r;
      rotl = d[127:64];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/xxh64_if.sv
`default_nettype none
interface xxh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, message_word, byte_count, last_word, input ready);
  modport sink (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface xxh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface
`default_nettype wire

### rtl/xxh64_front.sv
`default_nettype none
module xxh64_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [63:0]     in_word,
  input  wire logic [3:0]      in_count,
  input  wire logic            in_last,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output xxh64_pkg::item_t     q_item
);
  // two-entry queue of classified items
  xxh64_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       in_msg_r;
  xxh64_pkg::item_t cls;
  logic push, pop;

  always_comb begin
    cls.word  = in_word;
    cls.last  = in_last;
    cls.first = ~in_msg_r;
    if (!in_last) cls.n = 4'd8;
    else if (in_count > 4'd8) cls.n = 4'd8;
    else cls.n = in_count;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid & in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid & q_ready;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      in_msg_r <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        in_msg_r <= ~in_last;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### rtl/xxh64_back.sv
`default_nettype none
module xxh64_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [63:0]      seed,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire xxh64_pkg::item_t q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [63:0]           out_digest
);
  xxh64_pkg::state_t st_r, st_nxt;
  logic [63:0] acc_r [4];
  logic [63:0] sw_r [3];
  logic [1:0]  fill_r;
  logic [63:0] total_r;
  logic [63:0] h_r, t_r;
  logic [63:0] word_r;
  logic [3:0]  n_r;
  logic        last_r;
  logic [1:0]  li_r;
  logic [3:0]  bi_r;
  logic [63:0] dig_r;
  logic        take;
  logic [63:0] lane_w;
  logic [63:0] cur_acc [4];
  logic [63:0] total_v;
  logic [1:0]  fill_v;
  logic [7:0]  tb;
  logic [1:0]  mstep_r;
  logic [63:0] ma_r, mb_r, mp_r;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mprod;
  logic        mul_need, mul_done, hold;
  logic [63:0] mul_a, mul_b, mul_p;

  assign take = (st_r == xxh64_pkg::ST_IDLE) & q_valid;
  assign q_ready = (st_r == xxh64_pkg::ST_IDLE);
  assign out_valid = (st_r == xxh64_pkg::ST_OUT);
  assign out_digest = dig_r;
  assign lane_w = (li_r == 2'd3) ? word_r : sw_r[li_r];
  assign tb = t_r[7:0];

  // operand selection for the shared multiplier
  always_comb begin
    mul_need = 1'b0;
    mul_a = h_r;
    mul_b = xxh64_pkg::PR1;
    case (st_r)
      xxh64_pkg::ST_RND_MUL: begin
        mul_need = 1'b1;
        mul_a = lane_w;
        mul_b = xxh64_pkg::PR2;
      end
      xxh64_pkg::ST_RND_FIN: mul_need = 1'b1;
      xxh64_pkg::ST_MRG_A: begin
        mul_need = 1'b1;
        mul_a = acc_r[li_r];
        mul_b = xxh64_pkg::PR2;
      end
      xxh64_pkg::ST_MRG_C: begin
        mul_need = 1'b1;
        mul_a = word_r;
      end
      xxh64_pkg::ST_MRG_D: begin
        mul_need = 1'b1;
        mul_a = h_r ^ word_r;
      end
      xxh64_pkg::ST_W_A: begin
        if (li_r < fill_r) begin
          mul_need = 1'b1;
          mul_a = sw_r[li_r];
          mul_b = xxh64_pkg::PR2;
        end
      end
      xxh64_pkg::ST_W_C: begin
        mul_need = 1'b1;
        mul_a = word_r;
      end
      xxh64_pkg::ST_W_E: mul_need = 1'b1;
      xxh64_pkg::ST_H4_A: begin
        mul_need = 1'b1;
        mul_a = {32'd0, t_r[31:0]};
      end
      xxh64_pkg::ST_H4_C: begin
        mul_need = 1'b1;
        mul_b = xxh64_pkg::PR2;
      end
      xxh64_pkg::ST_B_A: begin
        mul_need = (bi_r < n_r && n_r != 4'd8);
        mul_a = {56'd0, tb};
        mul_b = xxh64_pkg::PR5;
      end
      xxh64_pkg::ST_B_C: mul_need = 1'b1;
      xxh64_pkg::ST_AV_A: begin
        mul_need = 1'b1;
        mul_a = h_r ^ (h_r >> 33);
        mul_b = xxh64_pkg::PR2;
      end
      xxh64_pkg::ST_AV_B: begin
        mul_need = 1'b1;
        mul_a = h_r ^ (h_r >> 29);
        mul_b = xxh64_pkg::PR3;
      end
      default: ;
    endcase
  end

  // low 64 bits of a 64x64 product from three 32x32 partial products
  always_comb begin
    case (mstep_r)
      2'd1: begin
        mop_a = ma_r[31:0];
        mop_b = mb_r[63:32];
      end
      2'd2: begin
        mop_a = ma_r[63:32];
        mop_b = mb_r[31:0];
      end
      default: begin
        mop_a = mul_a[31:0];
        mop_b = mul_b[31:0];
      end
    endcase
  end

  assign mprod = {32'd0, mop_a} * {32'd0, mop_b};
  assign mul_done = (mstep_r == 2'd2);
  assign mul_p = {mp_r[63:32] + mprod[31:0], mp_r[31:0]};
  assign hold = mul_need & ~mul_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= 2'd0;
    end else begin
      case (mstep_r)
        2'd0: if (mul_need) begin
          ma_r <= mul_a;
          mb_r <= mul_b;
          mp_r <= mprod;
          mstep_r <= 2'd1;
        end
        2'd1: begin
          mp_r[63:32] <= mp_r[63:32] + mprod[31:0];
          mstep_r <= 2'd2;
        end
        default: mstep_r <= 2'd0;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      xxh64_pkg::ST_IDLE: if (q_valid) st_nxt = xxh64_pkg::ST_CONV;
      xxh64_pkg::ST_CONV: begin
        if (n_r == 4'd8 && fill_r == 2'd3) st_nxt = xxh64_pkg::ST_RND_MUL;
        else if (last_r) st_nxt = (total_r >= xxh64_pkg::STRIPE_BYTES) ?
          xxh64_pkg::ST_MRG_A : xxh64_pkg::ST_LEN;
        else st_nxt = xxh64_pkg::ST_IDLE;
      end
      xxh64_pkg::ST_RND_MUL: st_nxt = xxh64_pkg::ST_RND_ACC;
      xxh64_pkg::ST_RND_ACC: st_nxt = xxh64_pkg::ST_RND_FIN;
      xxh64_pkg::ST_RND_FIN: begin
        if (li_r != 2'd3) st_nxt = xxh64_pkg::ST_RND_MUL;
        else if (last_r) st_nxt = (total_r >= xxh64_pkg::STRIPE_BYTES) ?
          xxh64_pkg::ST_MRG_A : xxh64_pkg::ST_LEN;
        else st_nxt = xxh64_pkg::ST_IDLE;
      end
      xxh64_pkg::ST_MRG_A: st_nxt = xxh64_pkg::ST_MRG_B;
      xxh64_pkg::ST_MRG_B: st_nxt = xxh64_pkg::ST_MRG_C;
      xxh64_pkg::ST_MRG_C: st_nxt = xxh64_pkg::ST_MRG_D;
      xxh64_pkg::ST_MRG_D: st_nxt = (li_r == 2'd3) ? xxh64_pkg::ST_LEN : xxh64_pkg::ST_MRG_A;
      xxh64_pkg::ST_LEN: st_nxt = xxh64_pkg::ST_W_A;
      xxh64_pkg::ST_W_A: begin
        if (li_r < fill_r) st_nxt = xxh64_pkg::ST_W_B;
        else if (n_r >= 4'd4 && n_r != 4'd8) st_nxt = xxh64_pkg::ST_H4_A;
        else st_nxt = xxh64_pkg::ST_B_A;
      end
      xxh64_pkg::ST_W_B: st_nxt = xxh64_pkg::ST_W_C;
      xxh64_pkg::ST_W_C: st_nxt = xxh64_pkg::ST_W_D;
      xxh64_pkg::ST_W_D: st_nxt = xxh64_pkg::ST_W_E;
      xxh64_pkg::ST_W_E: st_nxt = xxh64_pkg::ST_W_A;
      xxh64_pkg::ST_H4_A: st_nxt = xxh64_pkg::ST_H4_B;
      xxh64_pkg::ST_H4_B: st_nxt = xxh64_pkg::ST_H4_C;
      xxh64_pkg::ST_H4_C: st_nxt = xxh64_pkg::ST_B_A;
      xxh64_pkg::ST_B_A: st_nxt = (bi_r < n_r && n_r != 4'd8) ?
        xxh64_pkg::ST_B_B : xxh64_pkg::ST_AV_A;
      xxh64_pkg::ST_B_B: st_nxt = xxh64_pkg::ST_B_C;
      xxh64_pkg::ST_B_C: st_nxt = xxh64_pkg::ST_B_A;
      xxh64_pkg::ST_AV_A: st_nxt = xxh64_pkg::ST_AV_B;
      xxh64_pkg::ST_AV_B: st_nxt = xxh64_pkg::ST_AV_C;
      xxh64_pkg::ST_AV_C: st_nxt = xxh64_pkg::ST_OUT;
      xxh64_pkg::ST_OUT: if (out_ready) st_nxt = xxh64_pkg::ST_IDLE;
      default: st_nxt = xxh64_pkg::ST_IDLE;
    endcase
    if (hold) st_nxt = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= xxh64_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) cur_acc[i] = acc_r[i];
    total_v = total_r;
    fill_v = fill_r;
    if (q_item.first) begin
      cur_acc[0] = seed + xxh64_pkg::PR1 + xxh64_pkg::PR2;
      cur_acc[1] = seed + xxh64_pkg::PR2;
      cur_acc[2] = seed;
      cur_acc[3] = seed - xxh64_pkg::PR1;
      total_v = 64'd0;
      fill_v = 2'd0;
    end
  end

  // datapath: one shared multiplier, its product taken when it completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      total_r <= 64'd0;
    end else begin
      case (st_r)
        xxh64_pkg::ST_IDLE: if (take) begin
          for (int i = 0; i < 4; i++) acc_r[i] <= cur_acc[i];
          total_r <= total_v + {60'd0, q_item.n};
          fill_r <= fill_v;
          word_r <= q_item.word;
          t_r <= q_item.word;
          n_r <= q_item.n;
          last_r <= q_item.last;
        end
        xxh64_pkg::ST_CONV: begin
          li_r <= 2'd0;
          if (n_r == 4'd8 && fill_r != 2'd3) begin
            sw_r[fill_r] <= word_r;
            fill_r <= fill_r + 2'd1;
          end
        end
        xxh64_pkg::ST_RND_MUL: if (mul_done) h_r <= mul_p;
        xxh64_pkg::ST_RND_ACC: h_r <= xxh64_pkg::rotl(acc_r[li_r] + h_r, 6'd31);
        xxh64_pkg::ST_RND_FIN: if (mul_done) begin
          acc_r[li_r] <= mul_p;
          li_r <= li_r + 2'd1;
          if (li_r == 2'd3) fill_r <= 2'd0;
        end
        default: ;
      endcase
      case (st_r)
        xxh64_pkg::ST_MRG_A: begin
          if (li_r == 2'd0) h_r <= xxh64_pkg::rotl(acc_r[0], 6'd1) +
            xxh64_pkg::rotl(acc_r[1], 6'd7) + xxh64_pkg::rotl(acc_r[2], 6'd12) +
            xxh64_pkg::rotl(acc_r[3], 6'd18);
          if (mul_done) word_r <= mul_p;
        end
        xxh64_pkg::ST_MRG_B: word_r <= xxh64_pkg::rotl(word_r, 6'd31);
        xxh64_pkg::ST_MRG_C: if (mul_done) word_r <= mul_p;
        xxh64_pkg::ST_MRG_D: if (mul_done) begin
          h_r <= mul_p + xxh64_pkg::PR4;
          li_r <= li_r + 2'd1;
        end
        xxh64_pkg::ST_LEN: begin
          h_r <= ((total_r >= xxh64_pkg::STRIPE_BYTES) ? h_r :
                  acc_r[2] + xxh64_pkg::PR5) + total_r;
          li_r <= 2'd0;
        end
        xxh64_pkg::ST_W_A: if (mul_done) word_r <= mul_p;
        xxh64_pkg::ST_W_B: word_r <= xxh64_pkg::rotl(word_r, 6'd31);
        xxh64_pkg::ST_W_C: if (mul_done) word_r <= mul_p;
        xxh64_pkg::ST_W_D: h_r <= xxh64_pkg::rotl(h_r ^ word_r, 6'd27);
        xxh64_pkg::ST_W_E: if (mul_done) begin
          h_r <= mul_p + xxh64_pkg::PR4;
          li_r <= li_r + 2'd1;
        end
        default: ;
      endcase
      case (st_r)
        xxh64_pkg::ST_W_A: bi_r <= 4'd0;
        xxh64_pkg::ST_H4_A: if (mul_done) word_r <= mul_p;
        xxh64_pkg::ST_H4_B: h_r <= xxh64_pkg::rotl(h_r ^ word_r, 6'd23);
        xxh64_pkg::ST_H4_C: if (mul_done) begin
          h_r <= mul_p + xxh64_pkg::PR3;
          bi_r <= 4'd4;
          t_r <= {32'd0, t_r[63:32]};
        end
        xxh64_pkg::ST_B_A: if (mul_done) word_r <= mul_p;
        xxh64_pkg::ST_B_B: begin
          h_r <= xxh64_pkg::rotl(h_r ^ word_r, 6'd11);
          t_r <= {8'd0, t_r[63:8]};
          bi_r <= bi_r + 4'd1;
        end
        xxh64_pkg::ST_B_C: if (mul_done) h_r <= mul_p;
        xxh64_pkg::ST_AV_A: if (mul_done) h_r <= mul_p;
        xxh64_pkg::ST_AV_B: if (mul_done) h_r <= mul_p;
        xxh64_pkg::ST_AV_C: begin
          dig_r <= h_r ^ (h_r >> 32);
          fill_r <= 2'd0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/xxhash64_stream_digest.sv
`default_nettype none
// xxh64 digest of a byte message streamed as little-endian 64-bit words
// in channel: valid/ready, message_word, byte_count, last_word; a transfer
//   marked last ends the message, only it may carry fewer than 8 bytes
// out channel: valid/ready, digest; one transfer per message
// cfg: cfg_we/cfg_wdata load the seed, taken at the first word of a message
// a front stage classifies words into a two-entry queue, a back sequencer
// hashes on one shared 32x32 multiplier
// a word is registered in the queue before the back end takes it
// non-last word: buffered, or four lane rounds when it completes a stripe
// last word: lane rounds for a completed stripe, a merge (32 bytes or more),
//   the length step, one step per buffered word, a 4-byte step, one step per
//   tail byte and the avalanche, then the digest is offered
// the digest is held until the receiver takes it; the back end waits
// meanwhile while the queue still accepts up to two words
// reset: synchronous on rst_n low, seed clears to zero, queue empties
module xxhash64_stream_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  xxh64_in_if.sink         in_ch,
  xxh64_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata
);
  logic [63:0] seed_r;
  logic q_valid, q_ready;
  xxh64_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 64'd0;
    else if (cfg_we) seed_r <= cfg_wdata;
  end

  xxh64_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_word(in_ch.message_word), .in_count(in_ch.byte_count),
    .in_last(in_ch.last_word),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  xxh64_back u_back (
    .clk(clk), .rst_n(rst_n), .seed(seed_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_digest(out_ch.digest)
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest))
    else $error("digest dropped while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_ready)
    else $error("queue popped while digest pending");
`endif
endmodule
`default_nettype wire
